FILE: rtl/smkn_pkg.sv
// Shared types and codes for the sorted multiset k-th neighbor block.
// Used by every module under rtl; depends on nothing.
package smkn_pkg;

  localparam int KEY_W  = 64;
  localparam int RANK_W = 9;
  localparam int REQ_W  = 2;
  localparam int STS_W  = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PRED   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SUCC   = 2'd2;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [KEY_W-1:0]  key_value;
    logic [RANK_W-1:0]        rank;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0]         status;
    logic signed [KEY_W-1:0]  found_value;
  } out_item_t;

endpackage

FILE: rtl/sorted_multiset_kth_neighbor.sv
// Top level of the sorted multiset with k-th predecessor / successor queries.
// Instantiates a chain of smkn_cell; depends on smkn_pkg.
//
// Usage:
//   in_item (req_type, key_value, rank) is taken on in_valid && in_ready.
//   Insert places key_value after equal entries; a full table drops it (FULL).
//   Predecessor returns the rank-th largest entry <= key_value, successor the
//   rank-th smallest entry >= key_value; rank 0 or too few entries gives
//   NOT_FOUND with found_value zero. Unknown request codes give NOT_FOUND.
//   Every item yields exactly one out_item on out_valid && out_ready.
// Timing:
//   One item is in work at a time: compare in all cells, then count/shift,
//   then select into the output register. Its result shows after the compare,
//   the thermometer count and the cell select have each taken one registered
//   step and the output register is free. in_ready comes back in the same
//   cycle as out_valid, so a new item cannot be accepted before then.
//   in_ready returns while the result still waits in the output register;
//   if the receiver stalls, the next result waits until the register frees.
// Reset: rst_n (synchronous) empties the table and drops any pending result.
module sorted_multiset_kth_neighbor #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smkn_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output smkn_pkg::out_item_t out_item
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = ((CW > smkn_pkg::RANK_W) ? CW : smkn_pkg::RANK_W) + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [smkn_pkg::REQ_W-1:0]        req_r;
  logic signed [smkn_pkg::KEY_W-1:0] key_r;
  logic [smkn_pkg::RANK_W-1:0]       rank_r;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [IW-1:0]                     tgt_r, tgt_nxt;
  logic                              hit_r, hit_nxt;
  logic [smkn_pkg::STS_W-1:0]        sts_r, sts_nxt;
  logic                              out_valid_r, out_valid_nxt;
  smkn_pkg::out_item_t               out_r;

  logic                              cmp_en, shift_en;
  logic signed [smkn_pkg::KEY_W-1:0] val_w   [CAPACITY];
  logic                              le_w    [CAPACITY];
  logic                              lt_w    [CAPACITY];
  logic [CW-1:0]                     le_pos_w[CAPACITY];
  logic [CW-1:0]                     lt_pos_w[CAPACITY];
  logic signed [smkn_pkg::KEY_W-1:0] pick_w  [CAPACITY];

  logic [CW-1:0]                     cnt_le, cnt_lt, avail;
  logic signed [smkn_pkg::KEY_W-1:0] pick_or;
  logic [XW-1:0]                     rank_x;
  logic                              out_free;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      smkn_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (gi)
      ) u_cell (
        .clk        (clk),
        .cmp_en     (cmp_en),
        .shift_en   (shift_en),
        .count      (count_r),
        .key        (key_r),
        .tgt        (tgt_r),
        .prev_le    ((gi == 0) ? 1'b1 : le_w[(gi == 0) ? 0 : gi - 1]),
        .prev_value ((gi == 0) ? key_r : val_w[(gi == 0) ? 0 : gi - 1]),
        .next_le    ((gi == CAPACITY - 1) ? 1'b0 : le_w[(gi == CAPACITY - 1) ? gi : gi + 1]),
        .next_lt    ((gi == CAPACITY - 1) ? 1'b0 : lt_w[(gi == CAPACITY - 1) ? gi : gi + 1]),
        .value      (val_w[gi]),
        .le         (le_w[gi]),
        .lt         (lt_w[gi]),
        .le_pos     (le_pos_w[gi]),
        .lt_pos     (lt_pos_w[gi]),
        .pick       (pick_w[gi])
      );
    end
  endgenerate

  // only one cell drives a nonzero count / pick, so OR merges them
  always_comb begin
    cnt_le  = '0;
    cnt_lt  = '0;
    pick_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cnt_le  = cnt_le | le_pos_w[i];
      cnt_lt  = cnt_lt | lt_pos_w[i];
      pick_or = pick_or | pick_w[i];
    end
  end

  assign avail    = count_r - cnt_lt;
  assign rank_x   = XW'(rank_r);
  assign out_free = !out_valid_r || out_ready;
  assign cmp_en   = (state_r == ST_CMP);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tgt_nxt       = tgt_r;
    hit_nxt       = hit_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r;
    shift_en      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        hit_nxt = 1'b0;
        sts_nxt = smkn_pkg::STS_NOT_FOUND;
        tgt_nxt = '0;
        case (req_r)
          smkn_pkg::REQ_INSERT: begin
            if (count_r == CW'(CAPACITY)) begin
              sts_nxt = smkn_pkg::STS_FULL;
            end else begin
              shift_en  = 1'b1;
              count_nxt = count_r + 1'b1;
              sts_nxt   = smkn_pkg::STS_OK;
            end
          end
          smkn_pkg::REQ_PRED: begin
            if (rank_r != '0 && rank_x <= XW'(cnt_le)) begin
              hit_nxt = 1'b1;
              sts_nxt = smkn_pkg::STS_OK;
              tgt_nxt = IW'(XW'(cnt_le) - rank_x);
            end
          end
          smkn_pkg::REQ_SUCC: begin
            if (rank_r != '0 && rank_x <= XW'(avail)) begin
              hit_nxt = 1'b1;
              sts_nxt = smkn_pkg::STS_OK;
              tgt_nxt = IW'(XW'(cnt_lt) + rank_x - XW'(1));
            end
          end
          default: begin
          end
        endcase
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r  <= in_item.req_type;
      key_r  <= in_item.key_value;
      rank_r <= in_item.rank;
    end
    tgt_r <= tgt_nxt;
    sts_r <= sts_nxt;
    if (state_r == ST_OUT && out_free) begin
      out_r.status      <= sts_r;
      out_r.found_value <= hit_r ? pick_or : '0;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/smkn_cell.sv
// One storage cell of the sorted chain: holds a value, compares it with the key,
// shifts in from its lower neighbor on insert. Depends on smkn_pkg.
module smkn_cell #(
  parameter int CAPACITY = 256,
  parameter int IDX      = 0,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                               clk,
  input  logic                               cmp_en,
  input  logic                               shift_en,
  input  logic [CW-1:0]                      count,
  input  logic signed [smkn_pkg::KEY_W-1:0]  key,
  input  logic [IW-1:0]                      tgt,
  input  logic                               prev_le,
  input  logic signed [smkn_pkg::KEY_W-1:0]  prev_value,
  input  logic                               next_le,
  input  logic                               next_lt,
  output logic signed [smkn_pkg::KEY_W-1:0]  value,
  output logic                               le,
  output logic                               lt,
  output logic [CW-1:0]                      le_pos,
  output logic [CW-1:0]                      lt_pos,
  output logic signed [smkn_pkg::KEY_W-1:0]  pick
);

  logic signed [smkn_pkg::KEY_W-1:0] value_r;
  logic                              le_r;
  logic                              lt_r;
  logic                              occupied;

  assign occupied = CW'(IDX) < count;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      le_r <= occupied && (value_r <= key);
      lt_r <= occupied && (value_r < key);
    end
  end

  // insert: cells at or above the insert point move up one place
  always_ff @(posedge clk) begin
    if (shift_en && !le_r) begin
      value_r <= prev_le ? key : prev_value;
    end
  end

  assign value = value_r;
  assign le    = le_r;
  assign lt    = lt_r;

  // flags are a thermometer; the last set cell reports the count
  assign le_pos = (le_r && !next_le) ? CW'(IDX + 1) : '0;
  assign lt_pos = (lt_r && !next_lt) ? CW'(IDX + 1) : '0;
  assign pick   = (tgt == IW'(IDX)) ? value_r : '0;

endmodule

FILE: rtl/smkn_checker.sv
// Port-level checks for sorted_multiset_kth_neighbor, bound to the top level.
// Depends on smkn_pkg.
module smkn_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input smkn_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status == smkn_pkg::STS_OK ||
                  out_item.status == smkn_pkg::STS_NOT_FOUND ||
                  out_item.status == smkn_pkg::STS_FULL)
    else $error("bad status code");

  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != smkn_pkg::STS_OK |-> out_item.found_value == '0)
    else $error("nonzero value on miss");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind sorted_multiset_kth_neighbor smkn_checker u_smkn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
